[sv/amid_pkg.sv]
package amid_pkg;

    localparam int AXIS_W  = 16;
    localparam int DELTA_W = 18;
    localparam int TIME_W  = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [DELTA_W-1:0] THRESHOLD_RESET = DELTA_W'(1800);
    localparam logic [TIME_W-1:0]  TIMEOUT_RESET   = TIME_W'(30000);

    // Register indexes, decoded from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    // Item kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_ARM    = 1'b1;

    typedef struct packed {
        logic [DELTA_W-1:0] threshold;
        logic [TIME_W-1:0]  timeout;
    } t_cfg;

    // Control for an item in the lane stage, handed to the merge stage
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic              active;
        logic [TIME_W-1:0] now;
    } t_s1;

endpackage

[sv/amid_lane.sv]
module amid_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic                                i_update,
    input  logic signed [amid_pkg::AXIS_W-1:0]  i_sample,
    output logic        [amid_pkg::AXIS_W-1:0]  o_mag
);
    import amid_pkg::*;

    logic signed [AXIS_W-1:0] r_prev;
    logic signed [AXIS_W:0]   diff;
    logic signed [AXIS_W:0]   mag_full;
    logic        [AXIS_W-1:0] r_mag;

    // 17-bit difference never overflows; its magnitude fits in 16 bits
    assign diff     = {i_sample[AXIS_W-1], i_sample} - {r_prev[AXIS_W-1], r_prev};
    assign mag_full = diff[AXIS_W] ? -diff : diff;

    // hold the previous sample, advance only on a sample taken while armed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_update) begin
            r_prev <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= mag_full[AXIS_W-1:0];
        end
    end

    assign o_mag = r_mag;

endmodule

[sv/amid_merge.sv]
module amid_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  amid_pkg::t_s1                 i_s1,
    input  logic [amid_pkg::AXIS_W-1:0]   i_mag_x,
    input  logic [amid_pkg::AXIS_W-1:0]   i_mag_y,
    input  logic [amid_pkg::AXIS_W-1:0]   i_mag_z,
    input  amid_pkg::t_cfg                i_cfg,
    input  logic                          i_stall,
    output logic                          o_adv,
    output logic                          o_valid,
    output logic                          o_moving,
    output logic [amid_pkg::DELTA_W-1:0]  o_delta
);
    import amid_pkg::*;

    logic               r_valid;
    logic               r_flag;
    logic [DELTA_W-1:0] r_delta;
    logic [TIME_W-1:0]  r_last_ms;

    logic [DELTA_W-1:0] sum;
    logic [TIME_W-1:0]  elapsed;
    logic               take;
    logic               over;
    logic               expired;

    assign sum     = DELTA_W'(i_mag_x) + DELTA_W'(i_mag_y) + DELTA_W'(i_mag_z);
    assign elapsed = i_s1.now - r_last_ms;
    assign over    = sum > i_cfg.threshold;
    assign expired = elapsed >= i_cfg.timeout;

    assign o_adv = !r_valid || !i_stall;
    assign take  = i_s1.valid && o_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_flag    <= 1'b1;
            r_delta   <= '0;
            r_last_ms <= '0;
        end else begin
            if (o_adv) begin
                r_valid <= i_s1.valid;
            end
            if (take) begin
                if (i_s1.kind == REQ_ARM) begin
                    r_last_ms <= i_s1.now;
                end else if (i_s1.active) begin
                    r_delta <= sum;
                    if (over) begin
                        r_last_ms <= i_s1.now;
                        r_flag    <= 1'b1;
                    end else if (expired) begin
                        r_flag <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_moving = r_flag;
    assign o_delta  = r_delta;

endmodule

[sv/accel_motion_inactivity_detector_unit.sv]
// Accelerometer motion detector with inactivity timeout.
//
// Input channel: i_valid with o_stall. A beat carries i_req_type (sample or
// arm), the three signed axes and the millisecond time i_now_ms. A beat is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid with i_stall. Each input beat yields exactly one
// output beat carrying o_moving and o_motion_delta, in input order.
//
// Timing: two register stages. Three axis lanes register the absolute
// differences against the held previous sample; the merge stage sums them,
// compares with the threshold and the inactivity timeout, and its registers
// are the output. One beat per cycle is sustained while i_stall stays low,
// as the time bookkeeping closes its loop inside the merge stage registers.
//
// Receiver stall: the output beat holds; the lane stage, if empty, still takes
// one more beat, then o_stall rises until the output is taken.
// Reset (synchronous, i_rst_n low): pipeline empties, not armed, moving = 1,
// delta = 0, registers return to threshold 1800 and timeout 30000 ms.
// Configuration: APB, threshold at 0x0, timeout at 0x4; write only while idle.
module accel_motion_inactivity_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [amid_pkg::ADDR_W-1:0]         paddr,
    input  logic [amid_pkg::DATA_W-1:0]         pwdata,
    output logic [amid_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic signed [amid_pkg::AXIS_W-1:0]  i_accel_x,
    input  logic signed [amid_pkg::AXIS_W-1:0]  i_accel_y,
    input  logic signed [amid_pkg::AXIS_W-1:0]  i_accel_z,
    input  logic [amid_pkg::TIME_W-1:0]         i_now_ms,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_moving,
    output logic [amid_pkg::DELTA_W-1:0]        o_motion_delta
);
    import amid_pkg::*;

    t_cfg  r_cfg;
    t_s1   r_s1;
    t_s1   n_s1;
    logic  r_armed;

    logic  cfg_wr;
    logic  s1_load;
    logic  accept;
    logic  update;
    logic  adv;
    logic [AXIS_W-1:0] mag_x;
    logic [AXIS_W-1:0] mag_y;
    logic [AXIS_W-1:0] mag_z;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RESET;
            r_cfg.timeout   <= TIMEOUT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_THRESHOLD) begin
                r_cfg.threshold <= pwdata[DELTA_W-1:0];
            end else begin
                r_cfg.timeout <= pwdata[TIME_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_TIMEOUT) begin
            prdata = r_cfg.timeout;
        end else begin
            prdata = DATA_W'(r_cfg.threshold);
        end
    end

    // ---------------- input handshake and lane stage ----------------
    // The lane stage loads when empty or when the merge stage takes its beat.
    assign s1_load = !r_s1.valid || adv;
    assign o_stall = !s1_load;
    assign accept  = i_valid && s1_load;
    // Samples count only once armed; the arm beat itself is not a sample.
    assign update  = accept && (i_req_type == REQ_SAMPLE) && r_armed;

    always_comb begin
        n_s1.valid  = accept;
        n_s1.kind   = i_req_type;
        n_s1.active = (i_req_type == REQ_SAMPLE) && r_armed;
        n_s1.now    = i_now_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_s1.valid <= 1'b0;
        end else begin
            if (accept && (i_req_type == REQ_ARM)) begin
                r_armed <= 1'b1;
            end
            if (s1_load) begin
                r_s1.valid <= n_s1.valid;
            end
        end
        // payload of the lane stage needs no reset
        if (s1_load) begin
            r_s1.kind   <= n_s1.kind;
            r_s1.active <= n_s1.active;
            r_s1.now    <= n_s1.now;
        end
    end

    amid_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_load),
        .i_update (update),
        .i_sample (i_accel_x),
        .o_mag    (mag_x)
    );

    amid_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_load),
        .i_update (update),
        .i_sample (i_accel_y),
        .o_mag    (mag_y)
    );

    amid_lane u_lane_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_load),
        .i_update (update),
        .i_sample (i_accel_z),
        .o_mag    (mag_z)
    );

    // ---------------- merge stage and output register ----------------
    amid_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1     (r_s1),
        .i_mag_x  (mag_x),
        .i_mag_y  (mag_y),
        .i_mag_z  (mag_z),
        .i_cfg    (r_cfg),
        .i_stall  (i_stall),
        .o_adv    (adv),
        .o_valid  (o_valid),
        .o_moving (o_moving),
        .o_delta  (o_motion_delta)
    );

`ifndef SYNTHESIS
    // Upstream is held back only when both stages are full and the output stalls.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && r_s1.valid))
        else $error("input stalled while pipeline has room");

    // A beat in the lane stage reaches the output register in the next cycle
    // whenever the output side can move.
    a_lane_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && (!o_valid || !i_stall)) |=> o_valid)
        else $error("lane stage beat lost");

    // Before the first arm beat, moving must read as set.
    a_unarmed_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_armed && o_valid) |-> o_moving)
        else $error("moving cleared while not armed");
`endif

endmodule

[bench/accel_motion_inactivity_detector_unit_tb.sv]
module accel_motion_inactivity_detector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amid_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_SEGMENTS = 6;
    localparam int SEGMENT_BEATS   = 300;
    localparam int DELTA_MAX       = 3 * 65535;

    // One input beat, laid out in the order of the payload ports
    typedef struct packed {
        logic                     kind;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic [TIME_W-1:0]        now;
    } t_accel_beat;

    // One output beat
    typedef struct packed {
        logic               moving;
        logic [DELTA_W-1:0] delta;
    } t_motion_status;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_req_type;
    logic signed [AXIS_W-1:0] i_accel_x;
    logic signed [AXIS_W-1:0] i_accel_y;
    logic signed [AXIS_W-1:0] i_accel_z;
    logic [TIME_W-1:0]        i_now_ms;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_moving;
    logic [DELTA_W-1:0]       o_motion_delta;

    accel_motion_inactivity_detector_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_moving       (o_moving),
        .o_motion_delta (o_motion_delta)
    );

    // Free-running 100 MHz clock
    always #5 i_clk = ~i_clk;

    // Beats waiting to go out, and statuses waiting to come back
    t_accel_beat    beat_q[$];
    t_motion_status status_q[$];
    t_motion_status status_head;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    bit in_taken      = 1'b0;

    // Shadow configuration, written alongside every register write
    logic [DELTA_W-1:0] cfg_threshold = THRESHOLD_RESET;
    logic [TIME_W-1:0]  cfg_timeout   = TIMEOUT_RESET;

    // Shadow detector state, at its reset values
    logic signed [AXIS_W-1:0] det_prev_x  = '0;
    logic signed [AXIS_W-1:0] det_prev_y  = '0;
    logic signed [AXIS_W-1:0] det_prev_z  = '0;
    logic [TIME_W-1:0]        det_last_ms = '0;
    logic                     det_moving  = 1'b1;
    logic                     det_armed   = 1'b0;
    logic [DELTA_W-1:0]       det_delta   = '0;

    // Stimulus generator memory: last axes sent and the running clock
    logic signed [AXIS_W-1:0] gen_x    = '0;
    logic signed [AXIS_W-1:0] gen_y    = '0;
    logic signed [AXIS_W-1:0] gen_z    = '0;
    logic [TIME_W-1:0]        gen_time = '0;

    function automatic logic [DELTA_W-1:0] axis_dist(input logic signed [AXIS_W-1:0] a,
                                                     input logic signed [AXIS_W-1:0] b);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) begin
            d = -d;
        end
        return DELTA_W'(d);
    endfunction

    // Advance the shadow detector by one accepted beat and return its status
    function automatic t_motion_status predict_status(input t_accel_beat b);
        t_motion_status     r;
        logic [DELTA_W-1:0] d;
        logic [TIME_W-1:0]  elapsed;
        if (b.kind == REQ_ARM) begin
            // arm: record the time, keep samples, flag and delta
            det_armed   = 1'b1;
            det_last_ms = b.now;
        end else if (det_armed) begin
            d = axis_dist(b.x, det_prev_x) + axis_dist(b.y, det_prev_y)
              + axis_dist(b.z, det_prev_z);
            det_delta  = d;
            det_prev_x = b.x;
            det_prev_y = b.y;
            det_prev_z = b.z;
            elapsed    = b.now - det_last_ms;
            if (d > cfg_threshold) begin
                det_last_ms = b.now;
                det_moving  = 1'b1;
            end else if (elapsed >= cfg_timeout) begin
                det_moving = 1'b0;
            end
        end
        // not armed yet: state holds, moving reads high
        r.moving = det_armed ? det_moving : 1'b1;
        r.delta  = det_delta;
        return r;
    endfunction

    // Driver: present the next pending beat, hold it while stalled
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                {i_req_type, i_accel_x, i_accel_y, i_accel_z, i_now_ms} <= beat_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, independent of the output
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: check each taken output beat, predict each taken input beat.
    // Outputs are sampled before this edge's updates land.
    always @(posedge i_clk) begin
        in_taken = i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_q.size() == 0) begin
                $error("unexpected output beat: moving=%0d motion_delta=%0d",
                       o_moving, o_motion_delta);
                fail_count++;
            end else begin
                status_head = status_q.pop_front();
                if (o_moving !== status_head.moving) begin
                    $error("moving: expected %0d, got %0d", status_head.moving, o_moving);
                    fail_count++;
                end
                if (o_motion_delta !== status_head.delta) begin
                    $error("motion_delta: expected %0d, got %0d",
                           status_head.delta, o_motion_delta);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && in_taken) begin
            status_q.push_back(predict_status({i_req_type, i_accel_x, i_accel_y,
                                               i_accel_z, i_now_ms}));
        end
    end

    // Watchdog: stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write a register, update the shadow copy, then read it back
    task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_THRESHOLD) begin
            cfg_threshold = value[DELTA_W-1:0];
        end else begin
            cfg_timeout = value;
        end
        readback = (idx == REG_THRESHOLD) ? DATA_W'(cfg_threshold) : cfg_timeout;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== readback) begin
            $error("prdata: expected %0h, got %0h", readback, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_beat(input logic kind, input logic signed [AXIS_W-1:0] x,
                             input logic signed [AXIS_W-1:0] y,
                             input logic signed [AXIS_W-1:0] z,
                             input logic [TIME_W-1:0] now);
        beat_q.push_back({kind, x, y, z, now});
    endtask

    // Pick one axis: quiet jitter around the last value, a wild value, or an extreme
    function automatic logic signed [AXIS_W-1:0] pick_axis(
            input logic signed [AXIS_W-1:0] last, input int mode, input int span);
        case (mode)
            0: return last + AXIS_W'(int'($urandom_range(0, 2 * span)) - span);
            1: return AXIS_W'($urandom());
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // Queue random beats: mostly quiet samples on an advancing clock, so the
    // timeout gets reached, mixed with bursts of motion, arms and time jumps
    task automatic queue_random_beats(input int count);
        t_accel_beat       b;
        int                mode;
        int                span;
        logic [TIME_W-1:0] step;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(0, 99);
            mode = (mode < 60) ? 0 : (mode < 85) ? 1 : 2;
            span = int'(cfg_threshold) / 3 + int'($urandom_range(0, 1));
            if (span > 32767) begin
                span = 32767;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: step = $urandom_range(0, cfg_timeout >> 2);
                5, 6:          step = cfg_timeout - 1 + $urandom_range(0, 2);
                7:             step = $urandom_range(0, 3);
                8:             step = $urandom();
                default:       step = $urandom_range(0, cfg_timeout);
            endcase
            gen_time += step;
            b.now = gen_time;
            if ($urandom_range(0, 99) < 4) begin
                // arm beat: axis fields are don't-care, drive noise on them
                b.kind = REQ_ARM;
                b.x    = AXIS_W'($urandom());
                b.y    = AXIS_W'($urandom());
                b.z    = AXIS_W'($urandom());
            end else begin
                b.kind = REQ_SAMPLE;
                b.x    = pick_axis(gen_x, mode, span);
                b.y    = pick_axis(gen_y, mode, span);
                b.z    = pick_axis(gen_z, mode, span);
                gen_x  = b.x;
                gen_y  = b.y;
                gen_z  = b.z;
            end
            beat_q.push_back(b);
        end
    endtask

    // Wait until every beat has gone out and every status has come back,
    // then let the pipeline settle
    task automatic drain_pipeline();
        do begin
            @(posedge i_clk);
            #1;
        end while (beat_q.size() != 0 || i_valid || status_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_req_type = REQ_SAMPLE;
        i_accel_x  = '0;
        i_accel_y  = '0;
        i_accel_z  = '0;
        i_now_ms   = '0;

        // Hold reset, then drop it between edges
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset configuration (threshold 1800, 30 s)
        send_idle_pct = 16;
        recv_idle_pct = 45;
        // samples before arming: ignored, moving reads high, delta stays zero
        push_beat(REQ_SAMPLE, 16'sh7fff, 16'sh8000, 16'sd100, 32'd5);
        push_beat(REQ_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF);
        // arm, axis fields ignored; first sample compares against zero
        push_beat(REQ_ARM, 16'sh1234, -16'sd5, 16'sd7, 32'd1000);
        push_beat(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd1000);
        // delta equal to threshold is not motion; one above is
        push_beat(REQ_SAMPLE, 16'sd600, 16'sd600, 16'sd600, 32'd1010);
        push_beat(REQ_SAMPLE, 16'sd1201, 16'sd1200, 16'sd1200, 32'd1020);
        // one ms short of the timeout, then exactly on it
        push_beat(REQ_SAMPLE, 16'sd1201, 16'sd1200, 16'sd1200, 32'd31019);
        push_beat(REQ_SAMPLE, 16'sd1201, 16'sd1200, 16'sd1200, 32'd31020);
        // full-scale swing: largest possible delta
        push_beat(REQ_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 32'd31021);
        push_beat(REQ_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'hFFFF_FF00);
        // elapsed time across the 32-bit wrap lands exactly on the timeout
        push_beat(REQ_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'h0000_7430);
        // re-arm while armed: new time, flag and delta kept
        push_beat(REQ_ARM, '1, '1, '1, 32'hFFFF_FFF0);
        push_beat(REQ_SAMPLE, 16'sd32757, 16'sh7fff, 16'sh7fff, 32'h0000_752E);
        push_beat(REQ_SAMPLE, 16'sd32757, 16'sh7fff, 16'sh7fff, 32'h0000_7600);
        push_beat(REQ_SAMPLE, -16'sd1, 16'sd0, 16'sd1, 32'h0000_7601);
        push_beat(REQ_ARM, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0000);
        push_beat(REQ_SAMPLE, -16'sd1, 16'sd0, 16'sd1, 32'h0000_7530);
        drain_pipeline();

        gen_x    = -16'sd1;
        gen_y    = 16'sd0;
        gen_z    = 16'sd1;
        gen_time = 32'h0000_7530;

        // Random segments: new settings each, idling pattern per pair
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            case (seg)
                0: begin
                    write_register(REG_THRESHOLD, $urandom_range(0, 4000));
                    write_register(REG_TIMEOUT, $urandom_range(100, 60000));
                end
                1: begin
                    write_register(REG_THRESHOLD, 32'd0);
                    write_register(REG_TIMEOUT, 32'd0);
                end
                2: begin
                    write_register(REG_THRESHOLD, DELTA_MAX);
                    write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
                end
                3: begin
                    write_register(REG_THRESHOLD, $urandom_range(0, 20000));
                    write_register(REG_TIMEOUT, $urandom_range(0, 1000));
                end
                4: begin
                    write_register(REG_THRESHOLD, $urandom_range(0, DELTA_MAX));
                    write_register(REG_TIMEOUT, $urandom());
                end
                default: begin
                    write_register(REG_THRESHOLD, 32'(THRESHOLD_RESET));
                    write_register(REG_TIMEOUT, TIMEOUT_RESET);
                end
            endcase
            case (seg / 2)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            queue_random_beats(SEGMENT_BEATS);
            drain_pipeline();
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
